[hw/rtl/aabb_affine_transform_unit_defines.svh]
// Assertion macros shared by the box transform RTL.
// Expects clk and rst_n in the scope of each use; no other dependencies.
`ifndef AABB_AFFINE_TRANSFORM_UNIT_DEFINES_SVH
`define AABB_AFFINE_TRANSFORM_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define AAT_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define AAT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define AAT_ASSERT_IMPL(lbl, ante, cons)
`define AAT_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[hw/rtl/aat_pkg.sv]
// Types, widths and register codes for the box transform unit.
// No dependencies; used by aat_lane, aat_merge and the top level.
`timescale 1ns / 1ps

package aat_pkg;

    localparam int AXES    = 3;
    localparam int COORD_W = 32;
    localparam int COEF_W  = 16;
    localparam int FRAC_W  = 12;
    localparam int PROD_W  = COORD_W + COEF_W;
    localparam int TERM_W  = PROD_W - FRAC_W;
    localparam int SUM_W   = TERM_W + 2;
    localparam int ROW_W   = AXES * COEF_W;
    localparam int ROWS    = 4;
    localparam int DATA_W  = 2 * AXES * COORD_W;

    localparam logic [ROW_W-1:0] ROW_A_RESET   = 48'h0000_0000_1000;
    localparam logic [ROW_W-1:0] ROW_B_RESET   = 48'h0000_1000_0000;
    localparam logic [ROW_W-1:0] ROW_C_RESET   = 48'h1000_0000_0000;
    localparam logic [ROW_W-1:0] ROW_OFF_RESET = 48'h0000_0000_0000;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [COEF_W-1:0]  coef_t;
    typedef logic signed [TERM_W-1:0]  term_t;
    typedef logic signed [SUM_W-1:0]   sum_t;

    typedef enum logic [1:0] {
        REG_ROW_A,
        REG_ROW_B,
        REG_ROW_C,
        REG_ROW_OFFSET
    } reg_idx_t;

endpackage

[hw/rtl/aat_lane.sv]
// One lane per input axis: scales the low and high coordinate by the three
// coefficients of its matrix row, floors to Q16.16 and keeps min and max.
// Depends on aat_pkg.
`timescale 1ns / 1ps

module aat_lane
(
    input  logic           clk,
    input  logic           en,
    input  aat_pkg::coord_t lo,
    input  aat_pkg::coord_t hi,
    input  aat_pkg::coef_t  coef [aat_pkg::AXES],
    output aat_pkg::term_t  mn   [aat_pkg::AXES],
    output aat_pkg::term_t  mx   [aat_pkg::AXES]
);

    aat_pkg::term_t lo_term_reg [aat_pkg::AXES];
    aat_pkg::term_t hi_term_reg [aat_pkg::AXES];
    aat_pkg::term_t mn_reg      [aat_pkg::AXES];
    aat_pkg::term_t mx_reg      [aat_pkg::AXES];

    for (genvar a = 0; a < aat_pkg::AXES; a++) begin : g_axis
        logic signed [aat_pkg::PROD_W-1:0] lo_prod;
        logic signed [aat_pkg::PROD_W-1:0] hi_prod;

        assign lo_prod = lo * coef[a];
        assign hi_prod = hi * coef[a];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                // drop the fraction bits: arithmetic shift gives floor
                lo_term_reg[a] <= $signed(lo_prod[aat_pkg::PROD_W-1:aat_pkg::FRAC_W]);
                hi_term_reg[a] <= $signed(hi_prod[aat_pkg::PROD_W-1:aat_pkg::FRAC_W]);
                if (lo_term_reg[a] < hi_term_reg[a])
                begin
                    mn_reg[a] <= lo_term_reg[a];
                    mx_reg[a] <= hi_term_reg[a];
                end
                else
                begin
                    mn_reg[a] <= hi_term_reg[a];
                    mx_reg[a] <= lo_term_reg[a];
                end
            end
        end

        assign mn[a] = mn_reg[a];
        assign mx[a] = mx_reg[a];
    end

endmodule

[hw/rtl/aat_merge.sv]
// Merge stage: adds the per-lane extremes and the offset for each output
// axis, then saturates to 32 bits. Depends on aat_pkg.
`timescale 1ns / 1ps

module aat_merge
(
    input  logic            clk,
    input  logic            en,
    input  aat_pkg::term_t  lane_mn [aat_pkg::AXES][aat_pkg::AXES],
    input  aat_pkg::term_t  lane_mx [aat_pkg::AXES][aat_pkg::AXES],
    input  aat_pkg::coef_t  offset  [aat_pkg::AXES],
    output aat_pkg::coord_t box_mn  [aat_pkg::AXES],
    output aat_pkg::coord_t box_mx  [aat_pkg::AXES]
);

    localparam int EXT_W = aat_pkg::SUM_W - aat_pkg::TERM_W;
    localparam int OFF_PAD = aat_pkg::SUM_W - aat_pkg::COEF_W - 4;

    aat_pkg::coord_t mn_reg [aat_pkg::AXES];
    aat_pkg::coord_t mx_reg [aat_pkg::AXES];

    function automatic aat_pkg::sum_t widen(aat_pkg::term_t t);
        return $signed({{EXT_W{t[aat_pkg::TERM_W-1]}}, t});
    endfunction

    function automatic aat_pkg::coord_t sat(aat_pkg::sum_t s);
        aat_pkg::sum_t hi_lim;
        aat_pkg::sum_t lo_lim;
        hi_lim = $signed({{(aat_pkg::SUM_W-aat_pkg::COORD_W+1){1'b0}},
                          {(aat_pkg::COORD_W-1){1'b1}}});
        lo_lim = $signed({{(aat_pkg::SUM_W-aat_pkg::COORD_W+1){1'b1}},
                          {(aat_pkg::COORD_W-1){1'b0}}});
        if (s > hi_lim)
            return hi_lim[aat_pkg::COORD_W-1:0];
        else if (s < lo_lim)
            return lo_lim[aat_pkg::COORD_W-1:0];
        else
            return s[aat_pkg::COORD_W-1:0];
    endfunction

    for (genvar a = 0; a < aat_pkg::AXES; a++) begin : g_axis
        aat_pkg::sum_t off_q;
        aat_pkg::sum_t sum_mn;
        aat_pkg::sum_t sum_mx;

        // offset is Q4.12 times w = 1.0, i.e. shifted up by four into Q16.16
        assign off_q  = $signed({{OFF_PAD{offset[a][aat_pkg::COEF_W-1]}}, offset[a], 4'b0000});
        assign sum_mn = widen(lane_mn[0][a]) + widen(lane_mn[1][a])
                      + widen(lane_mn[2][a]) + off_q;
        assign sum_mx = widen(lane_mx[0][a]) + widen(lane_mx[1][a])
                      + widen(lane_mx[2][a]) + off_q;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                mn_reg[a] <= sat(sum_mn);
                mx_reg[a] <= sat(sum_mx);
            end
        end

        assign box_mn[a] = mn_reg[a];
        assign box_mx[a] = mx_reg[a];
    end

endmodule

[hw/rtl/aabb_affine_transform_unit.sv]
// Axis-aligned box affine transform. Takes one box per word and returns the
// box that bounds its eight corners after the configured 4x3 affine matrix.
// Since each output coordinate is a separable sum, the per-axis extremes are
// found per term: three lanes (one per input axis) form floor(coord*coef) for
// both box ends and keep min and max, then a merge stage adds the lanes and
// the offset and saturates. Throughput is one box per clock while the output is
// not stalled; the pipeline registers are the product register, the min/max
// register and the merge register, and a stalled output holds all of them.
// A word taken during a stall waits in the input skid register until the
// pipeline advances. Matrix rows must be written through the cfg port only
// while no box is in flight; the block itself does not enforce this.
// Depends on aat_pkg, aat_lane, aat_merge and the assertion macro header.
`timescale 1ns / 1ps
`include "aabb_affine_transform_unit_defines.svh"

module aabb_affine_transform_unit
(
    input  logic                        clk,
    input  logic                        rst_n,
    // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
    input  logic [aat_pkg::DATA_W-1:0]  s_tdata,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // out_min_x, out_min_y, out_min_z, out_max_x, out_max_y, out_max_z
    output logic [aat_pkg::DATA_W-1:0]  m_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic                        cfg_we,
    input  logic [1:0]                  cfg_index,
    input  logic [aat_pkg::ROW_W-1:0]   cfg_data
);

    localparam int AX = aat_pkg::AXES;
    localparam int CW = aat_pkg::COORD_W;

    logic [aat_pkg::ROW_W-1:0]  row_reg [aat_pkg::ROWS];
    logic                       skid_valid_reg;
    logic [aat_pkg::DATA_W-1:0] skid_data_reg;
    logic                       v1_reg;
    logic                       v2_reg;
    logic                       v3_reg;
    logic                       en;
    logic                       in_valid;
    logic [aat_pkg::DATA_W-1:0] in_data;

    aat_pkg::term_t  lane_mn [AX][AX];
    aat_pkg::term_t  lane_mx [AX][AX];
    aat_pkg::coef_t  offset  [AX];
    aat_pkg::coord_t box_mn  [AX];
    aat_pkg::coord_t box_mx  [AX];

    // configuration rows
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg[aat_pkg::REG_ROW_A]      <= aat_pkg::ROW_A_RESET;
            row_reg[aat_pkg::REG_ROW_B]      <= aat_pkg::ROW_B_RESET;
            row_reg[aat_pkg::REG_ROW_C]      <= aat_pkg::ROW_C_RESET;
            row_reg[aat_pkg::REG_ROW_OFFSET] <= aat_pkg::ROW_OFF_RESET;
        end
        else if (cfg_we)
        begin
            case (aat_pkg::reg_idx_t'(cfg_index))
                aat_pkg::REG_ROW_A:      row_reg[aat_pkg::REG_ROW_A]      <= cfg_data;
                aat_pkg::REG_ROW_B:      row_reg[aat_pkg::REG_ROW_B]      <= cfg_data;
                aat_pkg::REG_ROW_C:      row_reg[aat_pkg::REG_ROW_C]      <= cfg_data;
                aat_pkg::REG_ROW_OFFSET: row_reg[aat_pkg::REG_ROW_OFFSET] <= cfg_data;
                default: ;
            endcase
        end
    end

    // whole pipeline advances together unless the output word is stalled
    assign en       = !v3_reg || m_tready;
    assign s_tready = !skid_valid_reg;
    assign in_valid = skid_valid_reg || s_tvalid;
    assign in_data  = skid_valid_reg ? skid_data_reg : s_tdata;

    // skid register: hold a word taken during a stall
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            skid_valid_reg <= 1'b0;
        else if (en)
            skid_valid_reg <= 1'b0;
        else if (s_tvalid && s_tready)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (!en && s_tvalid && s_tready)
            skid_data_reg <= s_tdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    for (genvar j = 0; j < AX; j++) begin : g_lane
        aat_pkg::coef_t lane_coef [AX];

        for (genvar a = 0; a < AX; a++) begin : g_coef
            assign lane_coef[a] = $signed(row_reg[j][a*aat_pkg::COEF_W +: aat_pkg::COEF_W]);
        end

        aat_lane u_lane
        (
            .clk  (clk),
            .en   (en),
            .lo   ($signed(in_data[j*CW +: CW])),
            .hi   ($signed(in_data[(AX+j)*CW +: CW])),
            .coef (lane_coef),
            .mn   (lane_mn[j]),
            .mx   (lane_mx[j])
        );

        assign offset[j] =
            $signed(row_reg[aat_pkg::REG_ROW_OFFSET][j*aat_pkg::COEF_W +: aat_pkg::COEF_W]);
        assign m_tdata[j*CW +: CW]      = box_mn[j];
        assign m_tdata[(AX+j)*CW +: CW] = box_mx[j];
    end

    aat_merge u_merge
    (
        .clk     (clk),
        .en      (en),
        .lane_mn (lane_mn),
        .lane_mx (lane_mx),
        .offset  (offset),
        .box_mn  (box_mn),
        .box_mx  (box_mx)
    );

    assign m_tvalid = v3_reg;

    `AAT_ASSERT_NEXT(a_skid_capture, s_tvalid && s_tready && !en, skid_valid_reg)
    `AAT_ASSERT_NEXT(a_in_enters, en && in_valid, v1_reg)
    `AAT_ASSERT_IMPL(a_x_order, v3_reg, box_mn[0] <= box_mx[0])
    `AAT_ASSERT_IMPL(a_y_order, v3_reg, box_mn[1] <= box_mx[1])
    `AAT_ASSERT_IMPL(a_z_order, v3_reg, box_mn[2] <= box_mx[2])

endmodule
